/* design/cma_pkg.sv */
// Package for the centered moving average block: field widths, payload structs
// and the command and status bundles that join the controller to the datapath.
// Depends on nothing; every other file in the design imports it.
package cma_pkg;

	localparam int SAMPLE_BITS    = 20;
	localparam int AVG_W          = SAMPLE_BITS + 1;
	localparam int RADIUS_W       = 5;
	localparam int RADIUS_COUNT   = 2 ** RADIUS_W;
	localparam int MAX_RADIUS_LIM = 31;
	localparam int LEN_W          = $clog2(2 * MAX_RADIUS_LIM + 2);
	localparam int SUM_W          = SAMPLE_BITS + LEN_W;
	localparam int RECIP_W        = SUM_W + 1;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last_sample;
	} sample_item_t;

	typedef struct packed {
		logic signed [AVG_W-1:0] average;
		logic                    end_of_run;
	} result_item_t;

	typedef struct packed {
		logic take_sample;
		logic classify;
		logic reduce;
		logic push_mean;
		logic push_fill;
		logic flush;
		logic clear_run;
	} cma_cmd_t;

	typedef struct packed {
		logic head;
		logic full;
		logic last;
		logic pend_zero;
		logic pend_one;
		logic out_free;
	} cma_status_t;

endpackage

/* design/cma_datapath.sv */
// Datapath of the centered moving average: sample ring, running sum, counters,
// reciprocal divider and the result register. Acts on controller commands, radius writes and the result handshake.
// Depends on cma_pkg.
module cma_datapath
	import cma_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_LIM
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cma_cmd_t            cmd,
	output cma_status_t         status,
	input  logic                cfg_write,
	input  logic [RADIUS_W-1:0] cfg_data,
	input  sample_item_t        sample_item,
	input  logic                result_ready,
	output logic                result_valid,
	output result_item_t        result_item
);

	localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	// Reciprocal of each window length, floor(2^SUM_W / (2r+1)).
	logic [RECIP_W-1:0] recip_lut [RADIUS_COUNT];
	for (genvar g = 0; g < RADIUS_COUNT; g++) begin : g_recip
		localparam logic [RECIP_W-1:0] RECIP_VAL =
			RECIP_W'((64'd1 << SUM_W) / (2 * g + 1));
		assign recip_lut[g] = RECIP_VAL;
	end

	logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

	logic [RADIUS_W-1:0]        radius_q;
	logic [CNT_W-1:0]           len_q;
	logic [RECIP_W-1:0]         recip_q;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           seen_q;
	logic [PTR_W-1:0]           wp_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       last_q;
	logic [SAMPLE_BITS-1:0]     rd_q;
	logic [SUM_W+RECIP_W-1:0]   prod_s1;
	logic [SUM_W-1:0]           sum_s1;
	logic [SAMPLE_BITS-1:0]     quot_s2;
	logic [SUM_W-1:0]           back_s2;
	logic                       out_valid_q;
	result_item_t               out_q;

	logic [RADIUS_W-1:0]    radius_sat;
	logic [CNT_W-1:0]       r_ext;
	logic [CNT_W-1:0]       wp_inc;
	logic [PTR_W-1:0]       wp_next;
	logic [CNT_W-1:0]       pend_raw;
	logic [CNT_W-1:0]       pend;
	logic [SUM_W-1:0]       rem;
	logic [SAMPLE_BITS-1:0] mean;
	logic                   end_flag;

	assign radius_sat = (cfg_data > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : cfg_data;
	assign r_ext      = CNT_W'(radius_q);
	assign wp_inc     = CNT_W'(wp_q) + 1'b1;
	assign wp_next    = (wp_inc == len_q) ? '0 : PTR_W'(wp_inc);
	assign pend_raw   = (seen_q > r_ext) ? (seen_q - r_ext) : '0;
	assign pend       = (pend_raw > r_ext) ? r_ext : pend_raw;

	// One compare and subtract corrects the reciprocal estimate.
	assign rem  = sum_s1 - back_s2;
	assign mean = (rem >= SUM_W'(len_q)) ? (quot_s2 + 1'b1) : quot_s2;

	assign end_flag = last_q && (cmd.flush ? (cnt_q == CNT_W'(1)) : (cnt_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			len_q    <= CNT_W'(1);
			recip_q  <= recip_lut[0];
		end else if (cfg_write) begin
			radius_q <= radius_sat;
			len_q    <= CNT_W'({radius_sat, 1'b1});
			recip_q  <= recip_lut[radius_sat];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			seen_q <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (cfg_write || cmd.clear_run) begin
			sum_q  <= '0;
			seen_q <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.take_sample) begin
				sum_q  <= sum_q + SUM_W'(sample_item.sample);
				wp_q   <= wp_next;
				last_q <= sample_item.last_sample;
				if (seen_q < len_q) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (cmd.classify) begin
				cnt_q <= pend;
			end
			if (cmd.reduce) begin
				sum_q <= sum_q - SUM_W'(rd_q);
			end
			if (cmd.push_fill && cmd.flush) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The write pointer already names the oldest slot when the read is issued.
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			ring_mem[wp_q] <= sample_item.sample;
		end
		if (cmd.classify) begin
			rd_q <= ring_mem[wp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			prod_s1 <= SUM_W'(sum_q) * recip_q;
			sum_s1  <= sum_q;
		end
		if (cmd.reduce) begin
			quot_s2 <= prod_s1[SUM_W +: SAMPLE_BITS];
			back_s2 <= SUM_W'(prod_s1[SUM_W +: SAMPLE_BITS]) * SUM_W'(len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_mean || cmd.push_fill) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_mean) begin
			out_q.average    <= AVG_W'({1'b0, mean});
			out_q.end_of_run <= end_flag;
		end else if (cmd.push_fill) begin
			out_q.average    <= '1;
			out_q.end_of_run <= end_flag;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	assign status.head      = (seen_q <= r_ext);
	assign status.full      = (seen_q == len_q);
	assign status.last      = last_q;
	assign status.pend_zero = (cnt_q == '0);
	assign status.pend_one  = (cnt_q == CNT_W'(1));
	assign status.out_free  = !out_valid_q || result_ready;

endmodule

/* design/cma_ctrl.sv */
// Controller state machine of the centered moving average. It sequences the
// datapath through sample intake, division and result pushes. Depends on cma_pkg.
module cma_ctrl
	import cma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        cfg_valid,
	input  cma_status_t status,
	output cma_cmd_t    cmd,
	output logic        sample_ready,
	output logic        cfg_ready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLASS = 3'd1;
	localparam logic [2:0] ST_NEG   = 3'd2;
	localparam logic [2:0] ST_REM   = 3'd3;
	localparam logic [2:0] ST_FIX   = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q) inside
			ST_IDLE: begin
				// A pending radius write goes first; the sample waits until it is taken.
				if (sample_valid && !cfg_valid) begin
					cmd.take_sample = 1'b1;
					state_d         = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				if (status.head) begin
					state_d = ST_NEG;
				end else if (status.full) begin
					state_d = ST_REM;
				end else begin
					state_d = status.last ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_REM: begin
				cmd.reduce = 1'b1;
				state_d    = ST_FIX;
			end
			ST_NEG, ST_FIX: begin
				if (status.out_free) begin
					cmd.push_fill = (state_q == ST_NEG);
					cmd.push_mean = (state_q == ST_FIX);
					if (status.last && status.pend_zero) begin
						cmd.clear_run = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = status.last ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.push_fill = 1'b1;
					cmd.flush     = 1'b1;
					if (status.pend_one) begin
						cmd.clear_run = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready    = (state_q == ST_IDLE);

endmodule

/* design/centered_moving_average.sv */
// Centered boxcar moving average. One sample is taken at a time: a sample whose
// result is a head fill value gets intake, classify and a fill push; a full-window
// mean gets intake, reciprocal multiply, back multiply and correction; a sample with
// no result gets intake and classify; the run's last sample adds up to radius trailing fills.
// A result still waiting in the output register stalls the controller at its next push.
// Reset (arst_n low) clears radius to 0 and empties the run; the ring is not cleared.
module centered_moving_average
	import cma_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_LIM
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  sample_item_t        sample_item,
	output logic                result_valid,
	input  logic                result_ready,
	output result_item_t        result_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RADIUS_W-1:0] cfg_data
);

	// Commands flow from the controller to the datapath, status flows back.
	cma_cmd_t    cmd;
	cma_status_t status;
	logic        cfg_write;

	// A radius transfer also restarts the current run. When a radius write and
	// a sample are offered together, the radius transfer is taken first.
	assign cfg_write = cfg_valid && cfg_ready;

	cma_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.cfg_valid    (cfg_valid),
		.status       (status),
		.cmd          (cmd),
		.sample_ready (sample_ready),
		.cfg_ready    (cfg_ready)
	);

	// The datapath holds the ring of the last 2*radius+1 samples, the running
	// sum and the divider that turns the sum into the truncated mean.
	cma_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.sample_item  (sample_item),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_item  (result_item)
	);

`ifndef SYNTHESIS
	// Only one sample is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while another is in work");

	// A radius write never shares an edge with a sample transfer.
	a_cfg_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(sample_valid && sample_ready))
		else $error("radius transfer together with a sample transfer");

	// A result is either a non-negative mean or the fill value.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result_item.average[AVG_W-1] || result_item.average == '1))
		else $error("result average out of range");
`endif

endmodule
